// ----- rtl/poi_pkg.sv -----
`timescale 1ns / 1ps
// poi_pkg: shared widths, constants and tables of the planar odometry integrator
// used by planar_odometry_integrator and its checker; depends on nothing else
package poi_pkg;

	// cordic micro-rotations per pass, 12 to 32
	localparam int CORDIC_STEPS = 24;
	localparam int ITER_W = $clog2(CORDIC_STEPS);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

	// field widths
	localparam int DT_W  = 20;
	localparam int VEL_W = 24;
	localparam int POS_W = 48;
	localparam int ANG_W = 32;
	localparam int PM_W  = 44;   // |velocity| * dt
	localparam int CR_W  = 44;   // cordic x / y datapath
	localparam int Z_W   = 34;   // cordic residual angle

	// stream packing
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 288;

	// configuration register indexes
	localparam logic [1:0] CFG_START_X = 2'd0;
	localparam logic [1:0] CFG_START_Y = 2'd1;
	localparam logic [1:0] CFG_START_Z = 2'd2;

	// 2^48 / (2 pi 1e6): yaw rate times dt to binary angle, q32
	localparam logic [31:0] YAW_TO_BAM   = 32'd44798134;
	// inverse cordic gain, q32 and q30
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic signed [CR_W-1:0] INV_GAIN_Q30 = 44'sd652032874;
	localparam logic signed [CR_W-1:0] ONE_Q30      = 44'sd1073741824;
	localparam logic signed [CR_W-1:0] NEG_ONE_Q30  = -44'sd1073741824;
	localparam logic signed [CR_W-1:0] HALF_LSB_Q16 = 44'sd32768;

	// distance: ((m << 16) + 500000) / 1e6 == ((m << 10) + 7812) / 15625
	localparam logic [53:0] DIV_BIAS   = 54'd7812;
	localparam logic [14:0] DIV_D      = 15'd15625;
	localparam logic [31:0] DIV_RECIP  = 32'd274877;   // floor(2^32 / 15625)
	localparam logic [1:0]  DIV_LAST_CHUNK = 2'd3;     // four 16-bit digits

	localparam logic [63:0] RND_HALF_Q32 = 64'h0000_0000_8000_0000;

	// atan(2^-i) in binary angle units
	localparam logic [31:0] ATAN_BAM [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

endpackage

// ----- rtl/planar_odometry_integrator.sv -----
`timescale 1ns / 1ps
// one tick at a time: a new tick is taken only in S_IDLE, once the shared 32x32
// multiplier sequence, the four-digit divide by 1e6 and two passes of the one cordic stage
// are done for the previous tick; the next tick is taken while a finished result still
// waits on m_tready
// reset (arst_n low, asynchronous): pose, heading, averages, start registers and
// sequencer clear; a write of start_x or start_y also loads the position
module planar_odometry_integrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tick_dt_us[19:0], cmd_forward[43:20], cmd_yaw_rate[67:44], zero pad
	input  logic [poi_pkg::S_DATA_W-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x[47:0], pos_y[95:48], pos_z[143:96], heading_angle[175:144],
	// quat_z[207:176], quat_w[239:208], avg_forward[263:240], avg_yaw_rate[287:264]
	output logic [poi_pkg::M_DATA_W-1:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MF   = 4'd1;
	localparam logic [3:0] S_MW   = 4'd2;
	localparam logic [3:0] S_YL   = 4'd3;
	localparam logic [3:0] S_YH   = 4'd4;
	localparam logic [3:0] S_HD   = 4'd5;
	localparam logic [3:0] S_DR   = 4'd6;
	localparam logic [3:0] S_DQ   = 4'd7;
	localparam logic [3:0] S_DF   = 4'd8;
	localparam logic [3:0] S_GL   = 4'd9;
	localparam logic [3:0] S_GH   = 4'd10;
	localparam logic [3:0] S_GD   = 4'd11;
	localparam logic [3:0] S_CR   = 4'd12;
	localparam logic [3:0] S_PU   = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	// control
	logic [3:0] state_q;
	logic [poi_pkg::ITER_W-1:0] iter_q;
	logic pass_q;
	logic [1:0] k_q;
	logic m_tvalid_q;

	// architectural state
	logic [poi_pkg::POS_W-1:0] start_x_q, start_y_q, start_z_q;
	logic [poi_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic [poi_pkg::ANG_W-1:0] heading_q;
	logic [poi_pkg::VEL_W-1:0] prev_fwd_q, prev_yaw_q;

	// datapath
	logic [63:0] prod_q;
	logic [poi_pkg::DT_W-1:0] dt_q;
	logic [poi_pkg::VEL_W-1:0] af_q, aw_q;
	logic [poi_pkg::PM_W-1:0] pf_mag_q;
	logic [11:0] pw_hi_q;
	logic [31:0] y_rnd_q, g_rnd_q;
	logic [poi_pkg::ANG_W-1:0] head_new_q;
	logic [13:0] rem_q;
	logic [15:0] qest_q;
	logic [39:0] quot_q;
	logic signed [poi_pkg::CR_W-1:0] x_q, y_q;
	logic signed [poi_pkg::Z_W-1:0] z_q;
	logic [poi_pkg::M_DATA_W-1:0] m_tdata_q;

	logic accept, cfg_wr, out_free;
	logic [poi_pkg::DT_W-1:0] in_dt;
	logic [poi_pkg::VEL_W-1:0] in_fwd, in_yaw, af_in, aw_in, af_mag, aw_mag;
	logic [poi_pkg::VEL_W:0] sum_f, sum_w;
	logic [31:0] mul_a, mul_b;
	logic [63:0] rnd_sum;
	logic [31:0] step_mag, step;
	logic [63:0] n_prime;
	logic [15:0] chunk;
	logic [29:0] div_t, div_diff;
	logic [14:0] rem_raw, rem_fix;
	logic [15:0] q_fix;
	logic [39:0] d_mag;
	logic signed [poi_pkg::CR_W-1:0] d_signed, cr_x0, xs, ys, x_rnd, y_rnd;
	logic [31:0] cr_ang, ang_fold;
	logic cr_flip;
	logic signed [poi_pkg::Z_W-1:0] atan_z;
	logic [27:0] dx_q16, dy_q16;
	logic [31:0] qz_clamp, qw_clamp;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;

	assign in_dt  = s_tdata[19:0];
	assign in_fwd = s_tdata[43:20];
	assign in_yaw = s_tdata[67:44];

	// average with previous, arithmetic shift
	assign sum_f = {prev_fwd_q[23], prev_fwd_q} + {in_fwd[23], in_fwd};
	assign sum_w = {prev_yaw_q[23], prev_yaw_q} + {in_yaw[23], in_yaw};
	assign af_in = sum_f[24:1];
	assign aw_in = sum_w[24:1];

	assign af_mag = af_q[23] ? (~af_q + 24'd1) : af_q;
	assign aw_mag = aw_q[23] ? (~aw_q + 24'd1) : aw_q;

	assign rnd_sum  = prod_q + poi_pkg::RND_HALF_Q32;
	// only the low 32 bits of the heading step matter
	assign step_mag = prod_q[31:0] + y_rnd_q;
	assign step     = aw_q[23] ? (~step_mag + 32'd1) : step_mag;

	// radix 2^16 long division by 15625, one digit per pass through S_DR, S_DQ and S_DF
	assign n_prime  = {10'd0, {pf_mag_q, 10'd0} + poi_pkg::DIV_BIAS};
	assign chunk    = n_prime[{k_q, 4'b0000} +: 16];
	assign div_t    = {rem_q, chunk};
	assign div_diff = div_t - prod_q[29:0];
	assign rem_raw  = div_diff[14:0];

	always_comb begin
		if (rem_raw >= poi_pkg::DIV_D) begin
			rem_fix = rem_raw - poi_pkg::DIV_D;
			q_fix   = qest_q + 16'd1;
		end else begin
			rem_fix = rem_raw;
			q_fix   = qest_q;
		end
	end

	assign d_mag    = prod_q[39:0] + {8'd0, g_rnd_q};
	assign d_signed = af_q[23] ? -$signed({4'b0000, d_mag}) : $signed({4'b0000, d_mag});

	// start of a cordic pass: position vector, or the quaternion at half heading
	always_comb begin
		if (state_q == S_GD) begin
			cr_x0  = d_signed;
			cr_ang = head_new_q;
		end else begin
			cr_x0  = poi_pkg::INV_GAIN_Q30;
			cr_ang = {head_new_q[31], head_new_q[31:1]};
		end
	end

	// fold into [-pi/2, pi/2) by a half turn
	assign cr_flip  = (cr_ang[31:30] == 2'b01) || (cr_ang[31:30] == 2'b10);
	assign ang_fold = {cr_ang[31] ^ cr_flip, cr_ang[30:0]};

	assign xs     = x_q >>> iter_q;
	assign ys     = y_q >>> iter_q;
	assign atan_z = $signed({2'b00, poi_pkg::ATAN_BAM[5'(iter_q)]});

	assign x_rnd  = x_q + poi_pkg::HALF_LSB_Q16;
	assign y_rnd  = y_q + poi_pkg::HALF_LSB_Q16;
	assign dx_q16 = x_rnd[43:16];
	assign dy_q16 = y_rnd[43:16];

	always_comb begin
		if (x_q > poi_pkg::ONE_Q30) begin
			qw_clamp = poi_pkg::ONE_Q30[31:0];
		end else if (x_q < poi_pkg::NEG_ONE_Q30) begin
			qw_clamp = poi_pkg::NEG_ONE_Q30[31:0];
		end else begin
			qw_clamp = x_q[31:0];
		end
		if (y_q > poi_pkg::ONE_Q30) begin
			qz_clamp = poi_pkg::ONE_Q30[31:0];
		end else if (y_q < poi_pkg::NEG_ONE_Q30) begin
			qz_clamp = poi_pkg::NEG_ONE_Q30[31:0];
		end else begin
			qz_clamp = y_q[31:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MF: begin
				mul_a = {8'd0, af_mag};
				mul_b = {12'd0, dt_q};
			end
			S_MW: begin
				mul_a = {8'd0, aw_mag};
				mul_b = {12'd0, dt_q};
			end
			S_YL: begin
				mul_a = prod_q[31:0];
				mul_b = poi_pkg::YAW_TO_BAM;
			end
			S_YH: begin
				mul_a = {20'd0, pw_hi_q};
				mul_b = poi_pkg::YAW_TO_BAM;
			end
			S_DR: begin
				mul_a = {2'd0, div_t};
				mul_b = poi_pkg::DIV_RECIP;
			end
			S_DQ: begin
				mul_a = {16'd0, prod_q[47:32]};
				mul_b = {17'd0, poi_pkg::DIV_D};
			end
			S_GL: begin
				mul_a = quot_q[31:0];
				mul_b = poi_pkg::INV_GAIN_Q32;
			end
			S_GH: begin
				mul_a = {24'd0, quot_q[39:32]};
				mul_b = poi_pkg::INV_GAIN_Q32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iter_q     <= '0;
			pass_q     <= 1'b0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_MF;
				S_MF:   state_q <= S_MW;
				S_MW:   state_q <= S_YL;
				S_YL:   state_q <= S_YH;
				S_YH:   state_q <= S_HD;
				S_HD: begin
					k_q     <= poi_pkg::DIV_LAST_CHUNK;
					state_q <= S_DR;
				end
				S_DR:   state_q <= S_DQ;
				S_DQ:   state_q <= S_DF;
				S_DF: begin
					if (k_q == 2'd0) begin
						state_q <= S_GL;
					end else begin
						k_q     <= k_q - 2'd1;
						state_q <= S_DR;
					end
				end
				S_GL:   state_q <= S_GH;
				S_GH:   state_q <= S_GD;
				S_GD: begin
					iter_q  <= '0;
					pass_q  <= 1'b0;
					state_q <= S_CR;
				end
				S_CR: begin
					if (iter_q == poi_pkg::ITER_LAST) begin
						iter_q  <= '0;
						state_q <= pass_q ? S_DONE : S_PU;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_PU: begin
					pass_q  <= 1'b1;
					state_q <= S_CR;
				end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pose, averages and start registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			start_z_q  <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			heading_q  <= '0;
			prev_fwd_q <= '0;
			prev_yaw_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				poi_pkg::CFG_START_X: begin
					start_x_q <= pwdata[47:0];
					pos_x_q   <= pwdata[47:0];
				end
				poi_pkg::CFG_START_Y: begin
					start_y_q <= pwdata[47:0];
					pos_y_q   <= pwdata[47:0];
				end
				poi_pkg::CFG_START_Z: start_z_q <= pwdata[47:0];
				default: ;
			endcase
		end else if (state_q == S_PU) begin
			pos_x_q    <= pos_x_q + {{20{dx_q16[27]}}, dx_q16};
			pos_y_q    <= pos_y_q + {{20{dy_q16[27]}}, dy_q16};
			heading_q  <= head_new_q;
			prev_fwd_q <= af_q;
			prev_yaw_q <= aw_q;
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			poi_pkg::CFG_START_X: prdata = {{16{start_x_q[47]}}, start_x_q};
			poi_pkg::CFG_START_Y: prdata = {{16{start_y_q[47]}}, start_y_q};
			poi_pkg::CFG_START_Z: prdata = {{16{start_z_q[47]}}, start_z_q};
			default:              prdata = '0;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					dt_q <= in_dt;
					af_q <= af_in;
					aw_q <= aw_in;
				end
			end
			S_MW: pf_mag_q <= prod_q[43:0];
			S_YL: pw_hi_q <= prod_q[43:32];
			S_YH: y_rnd_q <= rnd_sum[63:32];
			S_HD: begin
				head_new_q <= heading_q + step;
				rem_q      <= '0;
				quot_q     <= '0;
			end
			S_DQ: qest_q <= prod_q[47:32];
			S_DF: begin
				rem_q  <= rem_fix[13:0];
				quot_q <= {quot_q[23:0], q_fix};
			end
			S_GH: g_rnd_q <= rnd_sum[63:32];
			S_GD, S_PU: begin
				x_q <= cr_flip ? -cr_x0 : cr_x0;
				y_q <= '0;
				z_q <= $signed({{2{ang_fold[31]}}, ang_fold});
			end
			S_CR: begin
				if (!z_q[poi_pkg::Z_W-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_z;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {prev_yaw_q, prev_fwd_q, qw_clamp, qz_clamp, heading_q,
						start_z_q, pos_y_q, pos_x_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/poi_checker.sv -----
`timescale 1ns / 1ps
// poi_checker: port-level assertions for planar_odometry_integrator
// bound to the top level below; uses poi_pkg for the result width
module poi_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [poi_pkg::M_DATA_W-1:0] m_tdata
);

	// one tick at a time: busy right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a tick transfer");

	// a result never appears in the cycle after its tick
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result valid rose one cycle after tick transfer");

	// the sequencer frees the input only once a result is posted
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("input ready rose without a posted result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);

// ----- bench/planar_odometry_integrator_tb.sv -----
`timescale 1ns / 1ps
// planar_odometry_integrator_tb: self-checking bench for the odometry integrator, with stream
// driver, result monitor, apb register writes and a bit-exact pose predictor; needs poi_pkg
module planar_odometry_integrator_tb;

	// tick_dt_us[19:0], cmd_forward[43:20], cmd_yaw_rate[67:44], zero pad
	typedef struct packed {
		logic [3:0]         pad;
		logic signed [23:0] cmd_yaw_rate;
		logic signed [23:0] cmd_forward;
		logic [19:0]        tick_dt_us;
	} tick_t;

	typedef struct packed {
		logic signed [23:0] avg_yaw_rate;
		logic signed [23:0] avg_forward;
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_z;
		logic [31:0]        heading_angle;
		logic signed [47:0] pos_z;
		logic signed [47:0] pos_y;
		logic signed [47:0] pos_x;
	} odom_result_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 800;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	localparam logic [19:0] DT_MAX  = 20'hF_FFFF;
	localparam logic [23:0] VEL_MAX = 24'h7F_FFFF;
	localparam logic [23:0] VEL_MIN = 24'h80_0000;
	localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;

	localparam logic [31:0] YAW_SCALE = 32'd44798134;
	localparam logic [31:0] GAIN_COMP = 32'd2608131496;
	localparam longint GAIN_COMP_Q30 = 64'sd652032874;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam logic [31:0] ANGLE_STEP [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [poi_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [poi_pkg::M_DATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	// predictor state
	logic [47:0] pose_x = '0, pose_y = '0;
	logic [31:0] heading_now = '0;
	logic [23:0] avg_fwd_now = '0, avg_yaw_now = '0;
	logic [47:0] start_reg [3] = '{default: '0};

	tick_t tick_queue [$];
	odom_result_t pose_expect_q [$];
	int error_count = 0;
	int cycle_count = 0;
	bit idle_on = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int send_gap = 0;
	int recv_gap = 0;

	planar_odometry_integrator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// a * c / 2^32, rounded half away from zero
	function automatic longint round_scale(input longint a, input logic [31:0] c);
		logic [63:0] mag, prod;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		prod = (mag >> 32) * {32'd0, c}
			+ (((mag & 64'hFFFF_FFFF) * {32'd0, c} + 64'h8000_0000) >> 32);
		return (a < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic void cordic_rotate(input longint x_in, input logic [31:0] angle,
			output longint x_out, output longint y_out);
		longint x, y, z, t;
		logic [31:0] a;
		int i;
		x = x_in;
		y = 0;
		a = angle;
		// fold the second and third quadrants by a half turn
		if (a[31] != a[30]) begin
			a = a + 32'h8000_0000;
			x = -x;
		end
		z = longint'($signed(a));
		for (i = 0; i < poi_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				t = x - (y >>> (i & 31));
				y = y + (x >>> (i & 31));
				z = z - longint'(ANGLE_STEP[i & 31]);
			end else begin
				t = x + (y >>> (i & 31));
				y = y - (x >>> (i & 31));
				z = z + longint'(ANGLE_STEP[i & 31]);
			end
			x = t;
		end
		x_out = x;
		y_out = y;
	endfunction

	function automatic longint clamp_unit(input longint v);
		if (v > UNIT_Q30)
			return UNIT_Q30;
		if (v < -UNIT_Q30)
			return -UNIT_Q30;
		return v;
	endfunction

	// integrates one tick into the predicted pose and returns the expected result
	function automatic odom_result_t advance_pose(input tick_t tk);
		longint dt, fwd_avg, yaw_avg, fwd_prod, yaw_prod, turn, travel, dx, dy, qw, qz;
		logic [63:0] mag, dmag;
		logic [31:0] head_next, half_head;
		odom_result_t r;
		dt = longint'(tk.tick_dt_us);
		fwd_avg = (longint'($signed(avg_fwd_now)) + longint'($signed(tk.cmd_forward))) >>> 1;
		yaw_avg = (longint'($signed(avg_yaw_now)) + longint'($signed(tk.cmd_yaw_rate))) >>> 1;
		fwd_prod = fwd_avg * dt;
		yaw_prod = yaw_avg * dt;
		turn = round_scale(yaw_prod, YAW_SCALE);
		head_next = heading_now + turn[31:0];
		// metres in q32, rounded half away from zero
		mag = (fwd_prod < 0) ? 64'(-fwd_prod) : 64'(fwd_prod);
		dmag = ((mag << 16) + 64'd500000) / 64'd1000000;
		travel = (fwd_prod < 0) ? -longint'(dmag) : longint'(dmag);
		travel = round_scale(travel, GAIN_COMP);
		cordic_rotate(travel, head_next, dx, dy);
		pose_x = pose_x + 48'((dx + 32768) >>> 16);
		pose_y = pose_y + 48'((dy + 32768) >>> 16);
		heading_now = head_next;
		avg_fwd_now = fwd_avg[23:0];
		avg_yaw_now = yaw_avg[23:0];
		half_head = 32'($signed(heading_now) >>> 1);
		cordic_rotate(GAIN_COMP_Q30, half_head, qw, qz);
		qw = clamp_unit(qw);
		qz = clamp_unit(qz);
		r.pos_x = pose_x;
		r.pos_y = pose_y;
		r.pos_z = start_reg[poi_pkg::CFG_START_Z];
		r.heading_angle = heading_now;
		r.quat_z = qz[31:0];
		r.quat_w = qw[31:0];
		r.avg_forward = avg_fwd_now;
		r.avg_yaw_rate = avg_yaw_now;
		return r;
	endfunction

	task automatic note_error(input string what);
		if (error_count < 10)
			$display("%s", what);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got)
			note_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
	endtask

	task automatic compare_pose(input odom_result_t want, input odom_result_t got);
		check_field("pos_x", want.pos_x, got.pos_x);
		check_field("pos_y", want.pos_y, got.pos_y);
		check_field("pos_z", want.pos_z, got.pos_z);
		check_field("heading_angle", want.heading_angle, got.heading_angle);
		check_field("quat_z", want.quat_z, got.quat_z);
		check_field("quat_w", want.quat_w, got.quat_w);
		check_field("avg_forward", want.avg_forward, got.avg_forward);
		check_field("avg_yaw_rate", want.avg_yaw_rate, got.avg_yaw_rate);
	endtask

	function automatic logic [23:0] pick_edge_vel();
		case ($urandom_range(0, 4))
		0: return VEL_MAX;
		1: return VEL_MIN;
		2: return 24'd0;
		3: return 24'd1;
		default: return 24'hFF_FFFF;
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t tk;
		tk = '0;
		case ($urandom_range(0, 3))
		0: begin
			tk.tick_dt_us = 20'($urandom);
			tk.cmd_forward = 24'($urandom);
			tk.cmd_yaw_rate = 24'($urandom);
		end
		1: begin
			// a plausible 20 ms control loop
			tk.tick_dt_us = 20'($urandom_range(15000, 25000));
			tk.cmd_forward = 24'($urandom_range(0, 262144)) - 24'd131072;
			tk.cmd_yaw_rate = 24'($urandom_range(0, 262144)) - 24'd131072;
		end
		2: begin
			tk.tick_dt_us = $urandom_range(0, 1) ? DT_MAX : 20'($urandom);
			tk.cmd_forward = pick_edge_vel();
			tk.cmd_yaw_rate = pick_edge_vel();
		end
		default: begin
			tk.tick_dt_us = 20'($urandom_range(0, 3));
			tk.cmd_forward = 24'($urandom);
			tk.cmd_yaw_rate = 24'($urandom);
		end
		endcase
		return tk;
	endfunction

	task automatic queue_tick(input logic [19:0] dt, input logic [23:0] fwd,
			input logic [23:0] yaw);
		tick_t tk;
		tk = '0;
		tk.tick_dt_us = dt;
		tk.cmd_forward = fwd;
		tk.cmd_yaw_rate = yaw;
		tick_queue.push_back(tk);
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || s_tvalid || pose_expect_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [47:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// out-of-range index is dropped by the block
		if (idx != CFG_UNUSED) begin
			start_reg[idx] = value;
			if (idx == poi_pkg::CFG_START_X)
				pose_x = value;
			else if (idx == poi_pkg::CFG_START_Y)
				pose_y = value;
		end
	endtask

	task automatic apb_read_check(input logic [1:0] idx);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", start_reg[idx], prdata[47:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_start(input logic [47:0] x, input logic [47:0] y, input logic [47:0] z);
		apb_write(poi_pkg::CFG_START_X, x);
		apb_write(poi_pkg::CFG_START_Y, y);
		apb_write(poi_pkg::CFG_START_Z, z);
		apb_read_check(poi_pkg::CFG_START_X);
		apb_read_check(poi_pkg::CFG_START_Y);
		apb_read_check(poi_pkg::CFG_START_Z);
	endtask

	task automatic random_phase(input int count, input bit with_idle, input bit squeeze);
		int k;
		idle_on = with_idle;
		if (squeeze)
			hold_requests++;
		for (k = 0; k < count; k++)
			tick_queue.push_back(random_tick());
		wait_drained();
	endtask

	// stream driver: one tick transfer per handshake, predicted on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				pose_expect_q.push_back(advance_pose(tick_t'(s_tdata)));
			if (s_tvalid && !s_tready) begin
				// keep offering the same tick
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (tick_queue.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 15);
				s_tvalid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				s_tdata <= tick_queue.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pose_expect_q.size() == 0)
					note_error($sformatf("unexpected result transfer: %h", m_tdata));
				else
					compare_pose(pose_expect_q.pop_front(), odom_result_t'(m_tdata));
			end
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				hold_left <= LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers come out of reset at zero
		apb_read_check(poi_pkg::CFG_START_X);
		apb_read_check(poi_pkg::CFG_START_Y);
		apb_read_check(poi_pkg::CFG_START_Z);

		// directed ticks on the reset pose
		idle_on = 1'b0;
		queue_tick(20'd0, 24'd0, 24'd0);
		queue_tick(20'd0, VEL_MAX, VEL_MAX);      // no elapsed time, averages still move
		queue_tick(20'd0, VEL_MIN, VEL_MIN);
		queue_tick(DT_MAX, VEL_MAX, VEL_MAX);
		queue_tick(DT_MAX, VEL_MAX, VEL_MAX);
		queue_tick(DT_MAX, VEL_MIN, VEL_MIN);
		queue_tick(DT_MAX, VEL_MIN, VEL_MIN);
		queue_tick(20'd1, 24'd1, -24'sd1);
		queue_tick(20'd1, -24'sd1, -24'sd1);      // averaging rounds toward minus infinity
		queue_tick(20'd20000, 24'd65536, 24'd102944);
		repeat (8)                                 // walk the heading through all quadrants
			queue_tick(DT_MAX, 24'd65536, 24'd49152);
		queue_tick(DT_MAX, 24'd0, VEL_MAX);        // several turns in one step
		queue_tick(DT_MAX, 24'd0, VEL_MAX);
		queue_tick(DT_MAX, -24'sd6553600, 24'd0);
		queue_tick(20'd12345, 24'd0, 24'd0);
		wait_drained();

		set_start(POS_MAX, POS_MIN, POS_MAX);
		apb_write(CFG_UNUSED, 48'h1234_5678_9ABC);
		apb_read_check(poi_pkg::CFG_START_X);
		random_phase(95, 1'b1, 1'b1);

		set_start(POS_MIN, POS_MAX, POS_MIN);
		random_phase(95, 1'b1, 1'b0);

		set_start(48'($urandom) << 16 | 48'($urandom), 48'($urandom) << 16 | 48'($urandom),
			48'($urandom) << 16 | 48'($urandom));
		random_phase(95, 1'b1, 1'b1);

		set_start(48'd0, 48'd0, 48'd0);
		random_phase(95, 1'b0, 1'b0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
